>>> sv/ihex_pkg.sv
// Shared types and constants for the Intel HEX record parser.
// No dependencies; imported by every module of the block.
package ihex_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [7:0] COLON_CHAR = 8'h3a;

  localparam logic [7:0] REC_DATA = 8'd0;
  localparam logic [7:0] REC_EOF  = 8'd1;
  localparam logic [7:0] REC_PAGE = 8'd4;
  localparam logic [7:0] REC_EXEC = 8'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_CSUM   = 3'd1;
  localparam logic [2:0] ST_PARITY = 3'd5;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic [2:0] line_error;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr_out;
    logic [7:0]  data_out;
    logic [2:0]  status;
  } result_t;

  // classified character: err_st is the finish status, ST_OK when no error
  typedef struct packed {
    logic       colon;
    logic [3:0] nib;
    logic [2:0] err_st;
  } tok_t;

endpackage

>>> sv/ihex_front.sv
// Front end: classifies incoming characters and line errors into tokens
// and holds them in a two-entry queue. Depends on ihex_pkg.
module ihex_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ihex_pkg::in_item_t in_item,
  output logic              tok_valid,
  output ihex_pkg::tok_t    tok,
  input  logic              tok_take
);
  import ihex_pkg::*;

  tok_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  tok_t       cls;
  logic       do_push;
  logic       do_pop;

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h57);
    return n;
  endfunction

  always_comb begin
    cls.colon = (in_item.char_in == COLON_CHAR);
    cls.nib   = hex_nib(in_item.char_in);
    if (in_item.line_error == 3'd0) cls.err_st = ST_OK;
    else if (in_item.line_error >= 3'd4) cls.err_st = ST_PARITY;
    else cls.err_st = in_item.line_error + 3'd1;
  end

  assign full      = (cnt == 2'd2);
  assign tok_valid = (cnt != 2'd0);
  assign tok       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = tok_take && tok_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/ihex_back.sv
// Back end: record parser state machine and two-entry result queue.
// Consumes tokens from ihex_front. Depends on ihex_pkg.
module ihex_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_data,
  input  logic             tok_valid,
  input  ihex_pkg::tok_t   tok,
  output logic             tok_take,
  output logic             empty,
  input  logic             pop,
  output ihex_pkg::result_t result
);
  import ihex_pkg::*;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_OFF   = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_PAGE  = 3'd5;
  localparam logic [2:0] PH_EXEC  = 3'd6;
  localparam logic [2:0] PH_CSUM  = 3'd7;

  logic [31:0] user_base;
  logic [2:0]  phase, phase_next;
  logic        low_next, low_next_next;
  logic [3:0]  high_nib, high_nib_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  record_count, record_count_next;
  logic [15:0] record_offset, record_offset_next;
  logic [7:0]  record_type, record_type_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [31:0] page_base, page_base_next;
  logic [31:0] field_accum, field_accum_next;
  logic [31:0] final_address, final_address_next;
  logic        finished, finished_next;

  logic        emit;
  result_t     res;
  logic [7:0]  b;
  logic [7:0]  bi_inc;
  logic [7:0]  sum_b;
  logic [31:0] page_val;

  result_t    oq [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_pop;

  assign tok_take = tok_valid && (cnt != 2'd2);
  assign empty    = (cnt == 2'd0);
  assign result   = oq[rd_ptr];
  assign do_pop   = pop && !empty;

  assign b        = {high_nib, tok.nib};
  assign bi_inc   = byte_index + 8'd1;
  assign sum_b    = running_sum + b;
  assign page_val = {field_accum[7:0], b, 16'h0000} & ADDR_MASK;

  always_comb begin
    phase_next         = phase;
    low_next_next      = low_next;
    high_nib_next      = high_nib;
    byte_index_next    = byte_index;
    record_count_next  = record_count;
    record_offset_next = record_offset;
    record_type_next   = record_type;
    running_sum_next   = running_sum;
    page_base_next     = page_base;
    field_accum_next   = field_accum;
    final_address_next = final_address;
    finished_next      = finished;
    emit               = 1'b0;
    res.kind           = KIND_FINISH;
    res.addr_out       = final_address & ADDR_MASK;
    res.data_out       = 8'd0;
    res.status         = ST_OK;

    if (!finished) begin
      if (phase == PH_HUNT) begin
        if (tok.err_st == ST_OK && tok.colon) begin
          phase_next    = PH_COUNT;
          low_next_next = 1'b0;
        end
      end else if (tok.err_st != ST_OK) begin
        emit          = 1'b1;
        res.status    = tok.err_st;
        finished_next = 1'b1;
        phase_next    = PH_HUNT;
      end else if (!low_next) begin
        high_nib_next = tok.nib;
        low_next_next = 1'b1;
      end else begin
        low_next_next = 1'b0;
        case (phase)
          PH_COUNT: begin
            record_count_next = b;
            running_sum_next  = b;
            byte_index_next   = 8'd0;
            field_accum_next  = 32'd0;
            phase_next        = PH_OFF;
          end
          PH_OFF: begin
            field_accum_next = {field_accum[23:0], b};
            running_sum_next = sum_b;
            byte_index_next  = bi_inc;
            if (bi_inc >= 8'd2) begin
              record_offset_next = {field_accum[7:0], b};
              phase_next         = PH_TYPE;
            end
          end
          PH_TYPE: begin
            record_type_next = b;
            running_sum_next = sum_b;
            byte_index_next  = 8'd0;
            field_accum_next = 32'd0;
            case (b)
              REC_DATA: begin
                final_address_next = (page_base + {16'h0000, record_offset}) & ADDR_MASK;
                phase_next = (record_count != 8'd0) ? PH_DATA : PH_CSUM;
              end
              REC_EOF:  phase_next = PH_CSUM;
              REC_PAGE: phase_next = PH_PAGE;
              REC_EXEC: phase_next = PH_EXEC;
              default:  phase_next = PH_HUNT;
            endcase
          end
          PH_DATA: begin
            emit             = 1'b1;
            res.kind         = KIND_WRITE;
            res.addr_out     = (final_address + {24'h000000, byte_index}) & ADDR_MASK;
            res.data_out     = b;
            running_sum_next = sum_b;
            byte_index_next  = bi_inc;
            if ({1'b0, bi_inc} >= {1'b0, record_count} || bi_inc == 8'd0) begin
              phase_next = PH_CSUM;
            end
          end
          PH_PAGE: begin
            field_accum_next = {field_accum[23:0], b};
            running_sum_next = sum_b;
            byte_index_next  = bi_inc;
            if (bi_inc >= 8'd2) begin
              page_base_next = (page_val == 32'd0) ? (user_base & ADDR_MASK) : page_val;
              phase_next     = PH_CSUM;
            end
          end
          PH_EXEC: begin
            field_accum_next = {field_accum[23:0], b};
            running_sum_next = sum_b;
            byte_index_next  = bi_inc;
            if (bi_inc >= 8'd4) begin
              final_address_next = {field_accum[23:0], b} & ADDR_MASK;
              phase_next         = PH_CSUM;
            end
          end
          PH_CSUM: begin
            phase_next = PH_HUNT;
            if (sum_b != 8'd0) begin
              emit          = 1'b1;
              res.status    = ST_CSUM;
              finished_next = 1'b1;
            end else if (record_type == REC_EOF) begin
              emit          = 1'b1;
              res.status    = ST_OK;
              finished_next = 1'b1;
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_base     <= 32'd0;
      phase         <= PH_HUNT;
      low_next      <= 1'b0;
      high_nib      <= 4'd0;
      byte_index    <= 8'd0;
      record_count  <= 8'd0;
      record_offset <= 16'd0;
      record_type   <= 8'd0;
      running_sum   <= 8'd0;
      page_base     <= 32'd0;
      field_accum   <= 32'd0;
      final_address <= 32'd0;
      finished      <= 1'b0;
    end else begin
      if (cfg_we) user_base <= cfg_data;
      if (tok_take) begin
        phase         <= phase_next;
        low_next      <= low_next_next;
        high_nib      <= high_nib_next;
        byte_index    <= byte_index_next;
        record_count  <= record_count_next;
        record_offset <= record_offset_next;
        record_type   <= record_type_next;
        running_sum   <= running_sum_next;
        page_base     <= page_base_next;
        field_accum   <= field_accum_next;
        final_address <= final_address_next;
        finished      <= finished_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && emit) oq[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (tok_take && emit) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, tok_take && emit} - {1'b0, do_pop};
    end
  end

endmodule

>>> sv/intel_hex_record_parser.sv
// Intel HEX record parser top level: ihex_front feeding ihex_back.
// Depends on ihex_pkg, ihex_front and ihex_back.
//
//   channel   handshake      payload
//   input     push / full    in_item  (char_in, line_error)
//   result    empty / pop    result   (kind, addr_out, data_out, status)
//   config    cfg_we         cfg_data (user_base)
//
// One character per cycle sustained while the result queue has room; the
// parser state machine in ihex_back retires one queued token per cycle.
// Tokens wait in the ihex_front queue; results are registered in the result
// queue. Each side has a two-entry queue; a stalled pop holds the parser only
// once the result queue is full. Synchronous reset clears all but queue data.
module intel_hex_record_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ihex_pkg::in_item_t in_item,
  output logic               empty,
  input  logic               pop,
  output ihex_pkg::result_t  result,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data
);
  import ihex_pkg::*;

  logic tok_valid;
  logic tok_take;
  tok_t tok;

  ihex_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_take  (tok_take)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_take  (tok_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
